### rtl/atce_pkg.sv
`timescale 1ns / 1ps
package atce_pkg;
  localparam int ESC_BUF_DEPTH = 16;
  localparam int EIW = $clog2(ESC_BUF_DEPTH);
  localparam int ECW = $clog2(ESC_BUF_DEPTH + 1);
  localparam int OUT_LIMIT = 32;

  typedef enum logic [3:0] {
    CMD_DRAW = 4'd0, CMD_SCROLL_UP = 4'd1, CMD_SCROLL_DOWN = 4'd2, CMD_SYNC = 4'd3,
    CMD_CLEAR = 4'd4, CMD_CLEAR_LINE = 4'd5, CMD_SWAP = 4'd6, CMD_CURSOR_OFF = 4'd7,
    CMD_CURSOR_PLACE = 4'd8
  } cmd_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [7:0]  pos_col;
    logic [7:0]  pos_row;
    logic [15:0] value;
    logic        last;
  } res_t;

  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_LBR = 8'h5b;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_QM = 8'h3f;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [16:0] NUM_SAT = 17'd65535;

  localparam logic [0:0] ADDR_COLS = 1'b0;
  localparam logic [0:0] ADDR_ROWS = 1'b1;
endpackage

### rtl/atce_ram.sv
`timescale 1ns / 1ps
module atce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/atce_out_fifo.sv
`timescale 1ns / 1ps
module atce_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  atce_pkg::res_t   din,
  output logic             full,
  output logic             tvalid,
  input  logic             tready,
  output atce_pkg::res_t   dout
);
  import atce_pkg::*;
  res_t q_r [2];
  logic [1:0] cnt_r;
  logic pop;
  assign pop = tvalid && tready;
  assign tvalid = cnt_r != 2'd0;
  assign dout = q_r[0];
  assign full = cnt_r == 2'd2;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (pop) begin
        q_r[0] <= q_r[1];
        if (push && cnt_r == 2'd1) q_r[0] <= din;
        else if (push) q_r[1] <= din;
      end else if (push) begin
        if (cnt_r == 2'd0) q_r[0] <= din;
        else q_r[1] <= din;
      end
    end
  end
endmodule

### rtl/ansi_text_console_engine.sv
`timescale 1ns / 1ps
// channel  | direction | beat
// in_      | slave     | tdata: char_code[7:0]
// out_     | master    | tdata: command[3:0] pos_col pos_row value[15:0]; tlast: last
// cfg_     | apb       | 0x0 screen_columns, 0x4 screen_rows
// a plain byte goes through S_PLAIN and S_FIN before ready returns, and through S_LDOWN
// too when it starts a new line. an escape byte is written to the buffer and the buffer
// is reparsed from the start, each parse step via S_PRS_RD and S_PRS; a completed
// sequence runs S_RUN, S_RUN2 (S_LUP or S_LDOWN for E and F) and S_PLACE, and a failed
// one replays each buffered byte via S_REP_RD, S_REP and S_PLAIN.
// reset clears cursor, count and flags. a full output queue stalls the sequencer in place.
module ansi_text_console_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // command, pos_col, pos_row, value, zero fill
  output logic        out_tlast,  // last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import atce_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PLAIN, S_LDOWN, S_LUP, S_ESC_WR, S_PRS_RD, S_PRS, S_RUN, S_RUN2, S_PLACE,
    S_REP_RD, S_REP, S_FIN
  } state_t;

  state_t st_r;
  logic [7:0] cols_r, rows_r, ccol_r, crow_r, ch_r;
  logic [ECW-1:0] ecnt_r, idx_r;
  logic hid_r, swp_r, rep_r, ld_rep_r;
  logic [2:0] ps_r;
  logic [15:0] n1_r, n2_r, ln_r;
  logic [7:0] fin_r;
  logic pend_v_r;
  res_t pend_r;

  logic we;
  logic [EIW-1:0] waddr, raddr;
  logic [7:0] rdata;
  atce_ram #(.WIDTH(8), .DEPTH(ESC_BUF_DEPTH)) u_buf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(ch_r), .raddr(raddr), .rdata(rdata));

  logic push, full, ovalid;
  res_t fout;
  logic [5:0] nres_r;
  res_t emit_d;
  logic emit_v;
  logic take;

  // last flag on the final pending result
  logic pend_last;
  res_t pend_out;
  assign pend_last = (st_r == S_FIN);
  assign pend_out = '{command: pend_r.command, pos_col: pend_r.pos_col,
                      pos_row: pend_r.pos_row, value: pend_r.value, last: pend_last};

  atce_out_fifo u_q (.clk(clk), .rst_n(rst_n), .push(push), .din(pend_out), .full(full),
    .tvalid(ovalid), .tready(out_tready), .dout(fout));
  assign out_tvalid = ovalid;
  assign out_tdata = {4'd0, fout.value, fout.pos_row, fout.pos_col, fout.command};
  assign out_tlast = fout.last;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? {24'd0, rows_r} : {24'd0, cols_r};
  assign in_tready = (st_r == S_IDLE) && !pend_v_r;

  logic [7:0] ce, re;
  assign ce = (cols_r == 8'd0) ? 8'd1 : cols_r;
  assign re = (rows_r == 8'd0) ? 8'd1 : rows_r;

  // holding a pending result lets us set last when the next one appears or item ends
  logic stall;
  assign stall = pend_v_r && full;
  assign take = emit_v && (nres_r < 6'(OUT_LIMIT));
  assign push = pend_v_r && !full && (take || st_r == S_FIN);

  assign we = (st_r == S_ESC_WR) && (ecnt_r < ECW'(ESC_BUF_DEPTH));
  assign waddr = ecnt_r[EIW-1:0];
  assign raddr = idx_r[EIW-1:0];

  function automatic logic is_dig(input logic [7:0] b);
    return b >= 8'd48 && b <= 8'd57;
  endfunction
  function automatic logic is_fin(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h48) || b == 8'h4a || b == 8'h4b || b == 8'h68 ||
           b == 8'h6c || b == 8'h6d;
  endfunction
  function automatic logic [15:0] add_d(input logic [15:0] v, input logic [7:0] b);
    logic [20:0] r;
    r = {5'd0, v} * 21'd10 + {17'd0, b[3:0]};
    return (r > {4'd0, NUM_SAT}) ? 16'hffff : r[15:0];
  endfunction
  function automatic res_t mk(input cmd_t c, input logic [7:0] col, input logic [7:0] row,
                              input logic [15:0] v);
    res_t r;
    r.command = c; r.pos_col = col; r.pos_row = row; r.value = v; r.last = 1'b0;
    return r;
  endfunction

  logic [16:0] sum;
  logic [8:0] t;
  always_comb begin
    emit_v = 1'b0;
    emit_d = mk(CMD_SYNC, 8'd0, 8'd0, 16'd0);
    sum = 17'd0;
    t = 9'd0;
    unique case (st_r)
      S_PLAIN: begin
        if (ch_r == CH_BS) begin
          emit_v = 1'b1;
          emit_d = (ccol_r == 8'd0) ?
            mk(CMD_DRAW, ce - 8'd1, (crow_r > 8'd0) ? crow_r - 8'd1 : 8'd0, 16'(CH_SP)) :
            mk(CMD_DRAW, ccol_r - 8'd1, crow_r, 16'(CH_SP));
        end else if (ch_r != CH_CR && ch_r != CH_LF && ch_r != CH_TAB && ch_r != CH_BEL) begin
          emit_v = 1'b1;
          emit_d = mk(CMD_DRAW, ccol_r, crow_r, {8'd0, ch_r});
        end
      end
      S_LDOWN: begin
        emit_v = 1'b1;
        sum = {9'd0, crow_r} + {1'b0, ln_r};
        if (sum >= {9'd0, re}) begin
          sum = sum - {9'd0, re} + 17'd1;
          emit_d = mk(CMD_SCROLL_UP, 8'd0, 8'd0, sum[16] ? 16'hffff : sum[15:0]);
        end
      end
      S_LUP: begin
        emit_v = 1'b1;
        if (ln_r > {8'd0, crow_r})
          emit_d = mk(CMD_SCROLL_DOWN, 8'd0, 8'd0, ln_r - {8'd0, crow_r});
      end
      S_RUN: begin
        emit_v = !hid_r;
        emit_d = mk(CMD_CURSOR_OFF, 8'd0, 8'd0, 16'd0);
      end
      S_RUN2: begin
        unique case (fin_r)
          8'h4a: begin emit_v = 1'b1; emit_d = mk(CMD_CLEAR, 8'd0, 8'd0, 16'd0); end
          8'h4b: begin
            emit_v = 1'b1;
            if (n1_r == 16'd0) emit_d = mk(CMD_CLEAR_LINE, ccol_r, crow_r, {8'd0, ce - 8'd1});
            else if (n1_r == 16'd1) emit_d = mk(CMD_CLEAR_LINE, 8'd0, crow_r, {8'd0, ccol_r});
            else emit_d = mk(CMD_CLEAR_LINE, 8'd0, crow_r, {8'd0, ce - 8'd1});
          end
          8'h6d: begin
            emit_v = (n1_r == 16'd0 && swp_r) || (n1_r == 16'd7 && !swp_r);
            emit_d = mk(CMD_SWAP, 8'd0, 8'd0, 16'd0);
          end
          default: ;
        endcase
      end
      S_PLACE: begin
        emit_v = !hid_r;
        emit_d = mk(CMD_CURSOR_PLACE, ccol_r, crow_r, 16'd0);
      end
      default: ;
    endcase
    t = {1'b0, ccol_r} + 9'd8;
    t[2:0] = 3'd0;
  end

  logic go;
  assign go = !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cols_r <= 8'd80; rows_r <= 8'd25; ccol_r <= 8'd0; crow_r <= 8'd0;
      ecnt_r <= '0; hid_r <= 1'b0; swp_r <= 1'b0; pend_v_r <= 1'b0; idx_r <= '0;
      rep_r <= 1'b0; ld_rep_r <= 1'b0; nres_r <= 6'd0; fin_r <= 8'd0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == ADDR_COLS) cols_r <= cfg_pwdata[7:0];
        else rows_r <= cfg_pwdata[7:0];
      end
      if (push) pend_v_r <= 1'b0;
      if (go && take) begin
        pend_r <= emit_d; pend_v_r <= 1'b1; nres_r <= nres_r + 6'd1;
      end
      if (go) begin
        unique case (st_r)
          S_IDLE: if (in_tvalid && in_tready) begin
            ch_r <= in_tdata; nres_r <= 6'd0; idx_r <= '0; rep_r <= 1'b0;
            if (in_tdata == CH_ESC) begin
              rep_r <= 1'b1;
              st_r <= (ecnt_r != '0) ? S_REP_RD : S_ESC_WR;
            end else if (ecnt_r != '0) st_r <= S_ESC_WR;
            else st_r <= S_PLAIN;
          end
          S_PLAIN: begin
            ln_r <= 16'd1;
            if (ch_r == CH_CR) ccol_r <= 8'd0;
            else if (ch_r == CH_LF) st_r <= S_LDOWN;
            else if (ch_r == CH_TAB) begin
              if (t >= {1'b0, ce}) st_r <= S_LDOWN; else ccol_r <= t[7:0];
            end else if (ch_r == CH_BS) begin
              if (ccol_r == 8'd0) begin
                ccol_r <= ce - 8'd1;
                if (crow_r > 8'd0) crow_r <= crow_r - 8'd1;
              end else ccol_r <= ccol_r - 8'd1;
            end else if (ch_r != CH_BEL) begin
              if ({1'b0, ccol_r} + 9'd1 >= {1'b0, ce}) st_r <= S_LDOWN;
              else ccol_r <= ccol_r + 8'd1;
            end
            if (!(ch_r == CH_LF || (ch_r == CH_TAB && t >= {1'b0, ce}) ||
                (ch_r != CH_CR && ch_r != CH_TAB && ch_r != CH_BS && ch_r != CH_BEL &&
                 {1'b0, ccol_r} + 9'd1 >= {1'b0, ce})))
              st_r <= ld_rep_r ? S_REP_RD : S_FIN;
          end
          S_LDOWN: begin
            ccol_r <= 8'd0;
            if ({9'd0, crow_r} + {1'b0, ln_r} >= {9'd0, re}) crow_r <= re - 8'd1;
            else crow_r <= crow_r + ln_r[7:0];
            st_r <= ld_rep_r ? S_REP_RD : (fin_r == 8'h46 && !rep_r ? S_PLACE : S_FIN);
          end
          S_LUP: begin
            ccol_r <= 8'd0;
            crow_r <= (ln_r > {8'd0, crow_r}) ? 8'd0 : crow_r - ln_r[7:0];
            st_r <= S_PLACE;
          end
          S_REP_RD: begin
            ld_rep_r <= 1'b1;
            if (idx_r >= ecnt_r || idx_r >= ECW'(ESC_BUF_DEPTH)) begin
              ld_rep_r <= 1'b0;
              ecnt_r <= '0; idx_r <= '0; ch_r <= CH_ESC;
              st_r <= rep_r ? S_ESC_WR : S_FIN;
            end else st_r <= S_REP;
          end
          S_REP: begin
            ch_r <= rdata; idx_r <= idx_r + ECW'(1); fin_r <= 8'd0; st_r <= S_PLAIN;
          end
          S_ESC_WR: begin
            if (rep_r) begin
              ch_r <= CH_ESC; ecnt_r <= ECW'(1); fin_r <= 8'd0; st_r <= S_FIN;
            end else begin
              ecnt_r <= ecnt_r + ECW'(1); idx_r <= '0; ps_r <= 3'd0;
              n1_r <= 16'd0; n2_r <= 16'd0;
              if (ecnt_r + ECW'(1) >= ECW'(ESC_BUF_DEPTH)) begin
                rep_r <= 1'b0; st_r <= S_REP_RD;
              end else st_r <= S_PRS_RD;
            end
          end
          S_PRS_RD: begin
            if (idx_r >= ecnt_r) st_r <= S_FIN; else st_r <= S_PRS;
          end
          S_PRS: begin
            st_r <= S_PRS_RD;
            unique case (ps_r)
              3'd0: begin
                idx_r <= idx_r + ECW'(1);
                if (rdata == CH_ESC) ps_r <= 3'd1; else begin idx_r <= '0; st_r <= S_REP_RD; end
              end
              3'd1: begin
                idx_r <= idx_r + ECW'(1);
                if (rdata == CH_LBR) ps_r <= 3'd2; else begin idx_r <= '0; st_r <= S_REP_RD; end
              end
              3'd2: begin
                if (is_dig(rdata)) begin n1_r <= {12'd0, rdata[3:0]}; ps_r <= 3'd3;
                  idx_r <= idx_r + ECW'(1); end
                else if (rdata == CH_QM) idx_r <= idx_r + ECW'(1);
                else begin n1_r <= 16'd1; ps_r <= 3'd4; end
              end
              3'd3: if (is_dig(rdata)) begin n1_r <= add_d(n1_r, rdata);
                  idx_r <= idx_r + ECW'(1); end else ps_r <= 3'd4;
              3'd4: if (rdata == CH_SEMI) begin ps_r <= 3'd5; idx_r <= idx_r + ECW'(1); end
                else ps_r <= 3'd7;
              3'd5: if (is_dig(rdata)) begin n2_r <= {12'd0, rdata[3:0]}; ps_r <= 3'd6;
                  idx_r <= idx_r + ECW'(1); end else begin idx_r <= '0; st_r <= S_REP_RD; end
              3'd6: if (is_dig(rdata)) begin n2_r <= add_d(n2_r, rdata);
                  idx_r <= idx_r + ECW'(1); end else ps_r <= 3'd7;
              default: begin
                idx_r <= '0;
                if (is_fin(rdata)) begin fin_r <= rdata; ecnt_r <= '0; st_r <= S_RUN; end
                else st_r <= S_REP_RD;
              end
            endcase
          end
          S_RUN: st_r <= S_RUN2;
          S_RUN2: begin
            st_r <= S_PLACE;
            ln_r <= n1_r;
            unique case (fin_r)
              8'h41: crow_r <= (n1_r >= {8'd0, crow_r}) ? 8'd0 : crow_r - n1_r[7:0];
              8'h42: crow_r <= ({9'd0, crow_r} + {1'b0, n1_r} >= {9'd0, re}) ? re - 8'd1 :
                               crow_r + n1_r[7:0];
              8'h43: ccol_r <= ({9'd0, ccol_r} + {1'b0, n1_r} >= {9'd0, ce}) ? ce - 8'd1 :
                               ccol_r + n1_r[7:0];
              8'h44: ccol_r <= (n1_r >= {8'd0, ccol_r}) ? 8'd0 : ccol_r - n1_r[7:0];
              8'h45: st_r <= S_LUP;
              8'h46: st_r <= S_LDOWN;
              8'h47: begin
                ccol_r <= (n1_r == 16'd0) ? 8'd0 :
                          (n1_r - 16'd1 > {8'd0, ce - 8'd1}) ? ce - 8'd1 : n1_r[7:0] - 8'd1;
                if (crow_r > re - 8'd1) crow_r <= re - 8'd1;
              end
              8'h48: begin
                ccol_r <= (n2_r == 16'd0) ? 8'd0 :
                          (n2_r - 16'd1 > {8'd0, ce - 8'd1}) ? ce - 8'd1 : n2_r[7:0] - 8'd1;
                crow_r <= (n1_r == 16'd0) ? 8'd0 :
                          (n1_r - 16'd1 > {8'd0, re - 8'd1}) ? re - 8'd1 : n1_r[7:0] - 8'd1;
              end
              8'h4a: begin ccol_r <= 8'd0; crow_r <= 8'd0; end
              8'h68: hid_r <= 1'b0;
              8'h6c: hid_r <= 1'b1;
              8'h6d: if (n1_r == 16'd0 && swp_r) swp_r <= 1'b0;
                else if (n1_r == 16'd7 && !swp_r) swp_r <= 1'b1;
              default: ;
            endcase
          end
          S_PLACE: st_r <= S_FIN;
          S_FIN: begin
            fin_r <= 8'd0; rep_r <= 1'b0; st_r <= S_IDLE;
          end
          default: st_r <= S_IDLE;
        endcase
      end
    end
  end
endmodule

### tb/sv/ansi_text_console_engine_test.sv
`timescale 1ns / 1ps
module ansi_text_console_engine_test;
  import atce_pkg::*;

  class console_scoreboard;
    int cols_reg = 80;
    int rows_reg = 25;
    int ccol, crow, ecount;
    bit hidden, swapped;
    logic [7:0] ebuf [ESC_BUF_DEPTH];
    res_t batch[$];
    res_t pending[$];
    int errors;

    function int cols_eff();
      return (cols_reg == 0) ? 1 : cols_reg;
    endfunction

    function int rows_eff();
      return (rows_reg == 0) ? 1 : rows_reg;
    endfunction

    function int sat16(longint v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return int'(v);
    endfunction

    function void emit(cmd_t c, int col, int row, int val);
      res_t r;
      if (batch.size() < OUT_LIMIT) begin
        r.command = c;
        r.pos_col = col[7:0];
        r.pos_row = row[7:0];
        r.value = val[15:0];
        r.last = 1'b0;
        batch.push_back(r);
      end
    endfunction

    function void line_down(int n);
      longint r;
      longint rows;
      r = longint'(crow) + n;
      rows = rows_eff();
      ccol = 0;
      if (r >= rows) begin
        emit(CMD_SCROLL_UP, 0, 0, sat16(r - rows + 1));
        crow = int'(rows - 1);
      end else begin
        emit(CMD_SYNC, 0, 0, 0);
        crow = int'(r);
      end
    endfunction

    function void line_up(int n);
      longint r;
      r = longint'(crow) - n;
      ccol = 0;
      if (r < 0) begin
        emit(CMD_SCROLL_DOWN, 0, 0, sat16(-r));
        crow = 0;
      end else begin
        emit(CMD_SYNC, 0, 0, 0);
        crow = int'(r);
      end
    endfunction

    function void place_clamped(int col, int row);
      int cm, rm;
      cm = cols_eff() - 1;
      rm = rows_eff() - 1;
      if (row < 0) row = 0;
      if (row > rm) row = rm;
      if (col < 0) col = 0;
      if (col > cm) col = cm;
      crow = row;
      ccol = col;
    endfunction

    function void plain_char(logic [7:0] c);
      int cols, t;
      cols = cols_eff();
      case (c)
        CH_CR: ccol = 0;
        CH_LF: line_down(1);
        CH_TAB: begin
          t = (ccol + 8) & ~7;
          if (t >= cols) line_down(1);
          else ccol = t;
        end
        CH_BS: begin
          if (ccol == 0) begin
            ccol = cols - 1;
            if (crow > 0) crow--;
          end else begin
            ccol--;
          end
          emit(CMD_DRAW, ccol, crow, 32);
        end
        CH_BEL: ;
        default: begin
          emit(CMD_DRAW, ccol, crow, int'(c));
          if (ccol + 1 >= cols) line_down(1);
          else ccol++;
        end
      endcase
    endfunction

    function void replay();
      for (int i = 0; i < ecount && i < ESC_BUF_DEPTH; i++) plain_char(ebuf[i]);
    endfunction

    function int add_digit(int v, int d);
      longint r;
      r = longint'(v) * 10 + d;
      return (r > 65535) ? 65535 : int'(r);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
    endfunction

    function bit is_final(logic [7:0] c);
      return (c >= "A" && c <= "H") || c == "J" || c == "K" || c == "h" || c == "l" ||
             c == "m";
    endfunction

    function void run_sequence(logic [7:0] fin, int n1, int n2);
      int cols, rows, v;
      cols = cols_eff();
      rows = rows_eff();
      if (!hidden) emit(CMD_CURSOR_OFF, 0, 0, 0);
      case (fin)
        "A": crow = (n1 >= crow) ? 0 : crow - n1;
        "B": begin
          v = crow + n1;
          if (v >= rows) v = rows - 1;
          crow = v;
        end
        "C": begin
          v = ccol + n1;
          if (v >= cols) v = cols - 1;
          ccol = v;
        end
        "D": ccol = (n1 >= ccol) ? 0 : ccol - n1;
        "E": line_up(n1);
        "F": line_down(n1);
        "G": place_clamped(n1 - 1, crow);
        "H": place_clamped(n2 - 1, n1 - 1);
        "J": begin
          emit(CMD_CLEAR, 0, 0, 0);
          place_clamped(0, 0);
        end
        "K": begin
          if (n1 == 0) emit(CMD_CLEAR_LINE, ccol, crow, cols - 1);
          else if (n1 == 1) emit(CMD_CLEAR_LINE, 0, crow, ccol);
          else emit(CMD_CLEAR_LINE, 0, crow, cols - 1);
        end
        "h": hidden = 1'b0;
        "l": hidden = 1'b1;
        default: begin
          if (n1 == 0 && swapped) begin
            emit(CMD_SWAP, 0, 0, 0);
            swapped = 1'b0;
          end else if (n1 == 7 && !swapped) begin
            emit(CMD_SWAP, 0, 0, 0);
            swapped = 1'b1;
          end
        end
      endcase
      if (!hidden) emit(CMD_CURSOR_PLACE, ccol, crow, 0);
    endfunction

    function void escape_char(logic [7:0] c);
      int i, st, n1, n2;
      logic [7:0] fin, b;
      bit fail, flush;
      i = 0; st = 0; n1 = 0; n2 = 0; fin = '0;
      fail = 1'b0; flush = 1'b0;
      if (ecount < ESC_BUF_DEPTH) ebuf[ecount] = c;
      ecount++;
      if (ecount >= ESC_BUF_DEPTH) fail = 1'b1;
      while (!fail && !flush && i < ecount && i < ESC_BUF_DEPTH) begin
        b = ebuf[i];
        case (st)
          0: begin if (b == CH_ESC) st = 1; else fail = 1'b1; i++; end
          1: begin if (b == CH_LBR) st = 2; else fail = 1'b1; i++; end
          2: begin
            if (is_digit(b)) begin n1 = int'(b) - 48; st = 3; i++; end
            else if (b == CH_QM) i++;
            else begin n1 = 1; st = 4; end
          end
          3: begin
            if (is_digit(b)) begin n1 = add_digit(n1, int'(b) - 48); i++; end
            else st = 4;
          end
          4: begin if (b == CH_SEMI) begin st = 5; i++; end else st = 7; end
          5: begin
            if (is_digit(b)) begin n2 = int'(b) - 48; st = 6; i++; end
            else fail = 1'b1;
          end
          6: begin
            if (is_digit(b)) begin n2 = add_digit(n2, int'(b) - 48); i++; end
            else st = 7;
          end
          default: begin
            if (is_final(b)) begin fin = b; flush = 1'b1; end
            else fail = 1'b1;
            i++;
          end
        endcase
      end
      if (fail) begin
        replay();
        ecount = 0;
      end else if (flush) begin
        ecount = 0;
        run_sequence(fin, n1, n2);
      end
    endfunction

    function void note_input(logic [7:0] c);
      batch.delete();
      if (c == CH_ESC) begin
        replay();
        ebuf[0] = CH_ESC;
        ecount = 1;
      end else if (ecount > 0) begin
        escape_char(c);
      end else begin
        plain_char(c);
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) pending.push_back(batch[k]);
    endfunction

    function void check_result(logic [39:0] d, logic l);
      res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: tdata %h tlast %b", d, l);
        return;
      end
      e = pending.pop_front();
      if (d[3:0] !== e.command || d[11:4] !== e.pos_col || d[19:12] !== e.pos_row ||
          d[35:20] !== e.value || d[39:36] !== 4'd0 || l !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected cmd %0d col %0d row %0d val %0d last %b, got %h/%b",
                   e.command, e.pos_col, e.pos_row, e.value, e.last, d, l);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [7:0] in_tdata = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;
  logic out_tlast;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  console_scoreboard screen_sb = new();
  bit quiet = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int sent = 0;

  ansi_text_console_engine dut (.*);

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) screen_sb.check_result(out_tdata, out_tlast);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_char(logic [7:0] c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    do @(posedge clk); while (!in_tready);
    screen_sb.note_input(c);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (screen_sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == {ADDR_ROWS, 2'b00}) screen_sb.rows_reg = int'(data[7:0]);
    else screen_sb.cols_reg = int'(data[7:0]);
    @(posedge clk);
  endtask

  task automatic send_number();
    int nd;
    nd = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 2);
    repeat (nd) send_char(8'(48 + $urandom_range(0, 9)));
  endtask

  task automatic send_sequence();
    string finals;
    bit broken;
    finals = "ABCDEFGHJKhlm";
    broken = ($urandom_range(0, 4) == 0);
    send_char(CH_ESC);
    if (broken && $urandom_range(0, 3) == 0) send_char(8'($urandom_range(0, 255)));
    else send_char(CH_LBR);
    if ($urandom_range(0, 5) == 0) send_char(CH_QM);
    if ($urandom_range(0, 3) != 0) send_number();
    if ($urandom_range(0, 2) == 0) begin
      send_char(CH_SEMI);
      if (!(broken && $urandom_range(0, 1))) send_number();
    end
    if (broken) send_char(8'($urandom_range(0, 255)));
    else send_char(finals[$urandom_range(0, finals.len() - 1)]);
  endtask

  task automatic random_phase(int count);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_sequence();
        4: send_char(8'($urandom_range(0, 255)));
        5: send_char(8'($urandom_range(7, 13)));
        6: begin
          send_char(CH_ESC);
          send_char(CH_LBR);
          repeat ($urandom_range(12, 16)) send_char(8'(48 + $urandom_range(0, 9)));
        end
        default: send_char(8'($urandom_range(32, 126)));
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_char(8'h00);
    send_char(8'hff);
    send_text("Az\t\x08\x07\r\n");
    send_text("\x1b[5;9H\x1b[?25l\x1b[7m\x1b[0m\x1b[h");
    send_text("\x1b[99999E\x1b[3F\x1b[K\x1b[1K\x1b[2K\x1b[J\x1b[Gx\x1b[;1H");
    send_text("\x1b[1\x1b[123456789012345678Q");
    drain();
    cfg_write({ADDR_COLS, 2'b00}, 32'd1);
    cfg_write({ADDR_ROWS, 2'b00}, 32'd1);
    random_phase(40);
    drain();
    cfg_write({ADDR_COLS, 2'b00}, 32'd255);
    cfg_write({ADDR_ROWS, 2'b00}, 32'd255);
    random_phase(60);
    drain();
    cfg_write({ADDR_COLS, 2'b00}, 32'd0);
    cfg_write({ADDR_ROWS, 2'b00}, 32'd0);
    random_phase(30);
    drain();
    cfg_write({ADDR_COLS, 2'b00}, $urandom_range(2, 20));
    cfg_write({ADDR_ROWS, 2'b00}, $urandom_range(2, 10));
    random_phase(70);
    drain();
    cfg_write({ADDR_COLS, 2'b00}, 32'd80);
    cfg_write({ADDR_ROWS, 2'b00}, 32'd25);
    random_phase(40);
    quiet = 1;
    random_phase(40);
    drain();
    if (screen_sb.errors == 0 && screen_sb.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
